// File: design/fpa_pkg.sv
// Package with opcodes and shared types for the fixed-point ALU.
`default_nettype none
package fpa_pkg;
  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
    OP_MIN = 4'd12, OP_MAX = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_t;

  localparam int unsigned DATA_W = 32;

  // Control that travels with an item down the cell chain.
  typedef struct packed {
    logic             vld;
    logic             neg;
    logic             is_div;
    logic             is_mul;
    logic             div_zero;
    logic [DATA_W-1:0] simple;
    logic             flag;
  } ctl_t;
endpackage
`default_nettype wire

// File: design/fpa_cell.sv
// One cell of the chain: a restoring-division step or a multiply-accumulate step.
`default_nettype none
module fpa_cell #(
  parameter int unsigned DW = 64,
  parameter int unsigned BW = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire fpa_pkg::ctl_t   ctl_i,
  input  wire logic [DW-1:0]   acc_i,
  input  wire logic [DW-1:0]   aux_i,
  input  wire logic [BW-1:0]   b_i,
  output fpa_pkg::ctl_t        ctl_o,
  output logic [DW-1:0]        acc_o,
  output logic [DW-1:0]        aux_o,
  output logic [BW-1:0]        b_o
);
  import fpa_pkg::*;

  // Division: aux holds {remainder,dividend} shifted; acc collects quotient bits.
  // Multiply: acc accumulates, aux holds the shifted multiplicand, b the multiplier.
  logic [DW-1:0] acc_nxt, aux_nxt;
  logic [BW-1:0] b_nxt;
  logic [BW:0]   rem_sh, trial;

  always_comb begin
    acc_nxt = acc_i;
    aux_nxt = aux_i;
    b_nxt   = b_i;
    rem_sh  = '0;
    trial   = '0;
    if (ctl_i.is_div) begin
      rem_sh = {aux_i[DW-1 -: BW], aux_i[DW-BW-1]};
      trial  = rem_sh - {1'b0, b_i};
      aux_nxt = {aux_i[DW-2:0], 1'b0};
      if (!trial[BW]) begin
        aux_nxt[DW-1 -: BW] = trial[BW-1:0];
        acc_nxt = {acc_i[DW-2:0], 1'b1};
      end else begin
        aux_nxt[DW-1 -: BW] = rem_sh[BW-1:0];
        acc_nxt = {acc_i[DW-2:0], 1'b0};
      end
    end else begin
      if (b_i[0]) begin
        acc_nxt = acc_i + aux_i;
      end
      aux_nxt = {aux_i[DW-2:0], 1'b0};
      b_nxt   = {1'b0, b_i[BW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.vld <= 1'b0;
    end else if (en) begin
      ctl_o.vld <= ctl_i.vld;
    end
    if (en) begin
      ctl_o.neg      <= ctl_i.neg;
      ctl_o.is_div   <= ctl_i.is_div;
      ctl_o.is_mul   <= ctl_i.is_mul;
      ctl_o.div_zero <= ctl_i.div_zero;
      ctl_o.simple   <= ctl_i.simple;
      ctl_o.flag     <= ctl_i.flag;
      acc_o <= acc_nxt;
      aux_o <= aux_nxt;
      b_o   <= b_nxt;
    end
  end
endmodule
`default_nettype wire

// File: design/fixed_point_alu_core.sv
// Top level of the pipelined fixed-point ALU built as a chain of cells.
//
// Usage: present mode, operand_a and operand_b with in_valid; the item is
// taken when in_valid and in_ready are both high. Each item gives exactly
// one result on out_value / out_flag, handed over when out_valid and
// out_ready are both high.
// Every opcode takes the same path through the cell chain and the output
// register, so results leave in the order items came in.
// Throughput: one item per cycle while the receiver does not stall.
// The chain has one cell per quotient bit of the
// (32 + FRAC_BITS)-bit scaled dividend; multiplies use the first 32 cells
// as shift-and-add steps. Simple opcodes ride along the chain.
// The whole chain advances as one pipeline: it moves when the output
// register is empty or being emptied, so a stalled receiver holds every
// stage and in_ready drops. Reset (synchronous, rst_n low) clears all
// valid bits; no item is lost or duplicated across a stall.
`default_nettype none
module fixed_point_alu_core #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_mode,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] out_value,
  output logic             out_flag
);
  import fpa_pkg::*;

  localparam int unsigned BW = DATA_W;
  localparam int unsigned NC = DATA_W + FRAC_BITS;
  localparam int unsigned DW = DATA_W + NC;

  ctl_t          ctl_c [0:NC];
  logic [DW-1:0] acc_c [0:NC];
  logic [DW-1:0] aux_c [0:NC];
  logic [BW-1:0] b_c   [0:NC];
  logic          en;

  logic [BW-1:0] a_u, b_u, mag_a, mag_b, simple;
  logic          lt_ab, lt_ba, flag;
  op_t           op;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Decode the item and work out the simple opcodes.
  always_comb begin
    op    = op_t'(in_mode);
    a_u   = in_operand_a;
    b_u   = in_operand_b;
    mag_a = a_u[BW-1] ? (~a_u + 1'b1) : a_u;
    mag_b = b_u[BW-1] ? (~b_u + 1'b1) : b_u;
    lt_ab = in_operand_a < in_operand_b;
    lt_ba = in_operand_b < in_operand_a;
    simple = '0;
    flag   = 1'b0;
    unique case (op)
      OP_ADD:      simple = a_u + b_u;
      OP_SUB:      simple = a_u - b_u;
      OP_GT:       flag = lt_ba;
      OP_LT:       flag = lt_ab;
      OP_GE:       flag = !lt_ab;
      OP_LE:       flag = !lt_ba;
      OP_EQ:       flag = a_u == b_u;
      OP_NE:       flag = a_u != b_u;
      OP_INC:      simple = a_u + 1'b1;
      OP_DEC:      simple = a_u - 1'b1;
      OP_MIN:      simple = lt_ab ? a_u : b_u;
      OP_MAX:      simple = lt_ba ? a_u : b_u;
      OP_FROM_INT: simple = a_u << FRAC_BITS;
      OP_TO_INT:   simple = BW'(in_operand_a >>> FRAC_BITS);
      default:     simple = '0;
    endcase
  end

  // Load the head of the chain.
  always_comb begin
    ctl_c[0].vld      = in_valid;
    ctl_c[0].neg      = a_u[BW-1] ^ b_u[BW-1];
    ctl_c[0].is_div   = (op == OP_DIV);
    ctl_c[0].is_mul   = (op == OP_MUL);
    ctl_c[0].div_zero = (b_u == '0);
    ctl_c[0].simple   = simple;
    ctl_c[0].flag     = flag;
    acc_c[0]          = '0;
    b_c[0]            = mag_b;
    if (op == OP_DIV) begin
      // Scaled dividend sits below an all-zero remainder field.
      aux_c[0] = DW'({mag_a, {FRAC_BITS{1'b0}}});
    end else begin
      aux_c[0] = DW'(mag_a);
    end
  end

  // The cell chain.
  for (genvar i = 0; i < NC; i++) begin : g_cell
    fpa_cell #(.DW(DW), .BW(BW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_c[i]),
      .acc_i (acc_c[i]),
      .aux_i (aux_c[i]),
      .b_i   (b_c[i]),
      .ctl_o (ctl_c[i+1]),
      .acc_o (acc_c[i+1]),
      .aux_o (aux_c[i+1]),
      .b_o   (b_c[i+1])
    );
  end

  // Finish: scale, sign and select the result.
  ctl_t          tail;
  logic [DW-1:0] mag_r;
  logic [BW-1:0] value_nxt;
  logic          out_valid_nxt;

  always_comb begin
    tail  = ctl_c[NC];
    mag_r = tail.is_div ? acc_c[NC] : (acc_c[NC] >> FRAC_BITS);
    if (tail.neg) begin
      mag_r = ~mag_r + 1'b1;
    end
    value_nxt = tail.simple;
    if (tail.is_div) begin
      value_nxt = tail.div_zero ? '0 : mag_r[BW-1:0];
    end else if (tail.is_mul) begin
      value_nxt = mag_r[BW-1:0];
    end
    out_valid_nxt = tail.vld;
  end

  // Output register.
  logic          out_valid_r;
  logic [BW-1:0] out_value_r;
  logic          out_flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_valid_nxt;
    end
    if (en) begin
      out_value_r <= value_nxt;
      out_flag_r  <= tail.flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_flag  = out_flag_r;
endmodule
`default_nettype wire
